>>> rtl/score_tag_bubble_sorter_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef SCORE_TAG_BUBBLE_SORTER_DEFINES_SVH
`define SCORE_TAG_BUBBLE_SORTER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define STBS_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define STBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/stbs_pkg.sv
`timescale 1ns / 1ps
package stbs_pkg;

  localparam int DEPTH_DEFAULT    = 32;
  localparam int TAG_BITS_DEFAULT = 16;

  localparam int SLOT_W      = 5;
  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 16;
  localparam int RANK_W      = 5;
  localparam int COUNT_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_START,
    ST_LOAD_CARRY,
    ST_COMPARE,
    ST_PASS_END,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

endpackage

>>> rtl/stbs_store.sv
`timescale 1ns / 1ps
module stbs_store #(
  parameter int DEPTH  = stbs_pkg::DEPTH_DEFAULT,
  parameter int WORD_W = stbs_pkg::SCORE_W + stbs_pkg::TAG_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data
);
  import stbs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;
  logic [WORD_W-1:0] rd_word;
  logic              rd_written;

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_word    <= mem[rd_addr];
    rd_written <= written[rd_addr];
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

>>> rtl/score_tag_bubble_sorter.sv
`timescale 1ns / 1ps
// Channel   Signals                                   Direction  Item
// in        in_valid/in_ready, slot score tag last    in         one record write
// out       out_valid/out_ready, out_score out_tag    out        one sorted record
//           rank final_res
// cfg       cfg_valid/cfg_ready, cfg_index cfg_data   in         one register write
//
// An item without last, or with last while entry_count is zero, leaves the block idle.
// With last and n >= 2 records in use, the records are bubble sorted in passes:
// the single compare unit and the single read port of the store do one compare
// per cycle, plus a carry load and a write-back per pass. With one record in use
// the sort is skipped. Each record is then read, loaded into the output registers
// and held until out_ready takes it; cfg is always ready.
// Reset is synchronous and clears the control registers and the store (through
// per-entry written bits, so no clearing pass is needed). With records in use, the
// input is stalled from a last item until its final result has been taken.
module score_tag_bubble_sorter #(
  parameter int DEPTH    = stbs_pkg::DEPTH_DEFAULT,
  parameter int TAG_BITS = stbs_pkg::TAG_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [stbs_pkg::SLOT_W-1:0]       slot,
  input  logic signed [stbs_pkg::SCORE_W-1:0] score,
  input  logic [stbs_pkg::TAG_W-1:0]        tag,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [stbs_pkg::SCORE_W-1:0] out_score,
  output logic [stbs_pkg::TAG_W-1:0]        out_tag,
  output logic [stbs_pkg::RANK_W-1:0]       rank,
  output logic                              final_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stbs_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = SCORE_W + TAG_BITS;

  // Configuration registers.
  logic [COUNT_W-1:0] entry_count;
  logic               descending;

  // Sequencer and sort registers.
  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   pass;
  logic [IDX_W-1:0]   k;
  logic [IDX_W-1:0]   e_idx;
  logic [WORD_W-1:0]  carry;

  // Store port signals.
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [WORD_W-1:0]  rd_data;

  // Derived values.
  logic [31:0]        count_full;
  logic [CNT_W-1:0]   n;
  logic [IDX_W-1:0]   nm1;
  logic               slot_ok;
  logic               swap;
  logic               in_acc;

  // The number of records in use is entry_count clamped to the store depth.
  assign count_full = (32'(entry_count) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(entry_count);
  assign n          = count_full[CNT_W-1:0];
  assign nm1        = IDX_W'(n - 1'b1);
  assign slot_ok    = 32'(slot) < 32'(n);
  assign in_acc     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;

  // The one compare unit. rd_data holds the record just below the carried one,
  // and a swap happens only on a strict compare so equal scores keep their order.
  always_comb begin
    if (descending) begin
      swap = $signed(rd_data[SCORE_W-1:0]) < $signed(carry[SCORE_W-1:0]);
    end else begin
      swap = $signed(carry[SCORE_W-1:0]) < $signed(rd_data[SCORE_W-1:0]);
    end
  end

  stbs_store #(
    .DEPTH  (DEPTH),
    .WORD_W (WORD_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state. Each pass walks from the top record down to the pass index,
  // carrying the smaller (or larger) record down like a bubble.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && last && (n != '0)) begin
          state_next = (nm1 == '0) ? ST_EMIT_READ : ST_PASS_START;
        end
      end
      ST_PASS_START: begin
        state_next = ST_LOAD_CARRY;
      end
      ST_LOAD_CARRY: begin
        state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (k == pass) begin
          state_next = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        state_next = (pass == nm1) ? ST_EMIT_READ : ST_LOAD_CARRY;
      end
      ST_EMIT_READ: begin
        state_next = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          state_next = final_res ? ST_IDLE : ST_EMIT_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Store port and handshake controls for each state.
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    rd_addr  = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_valid && slot_ok;
        wr_addr  = IDX_W'(slot);
        wr_data  = {TAG_BITS'(tag), score};
      end
      ST_PASS_START: begin
        rd_addr = k;
      end
      ST_LOAD_CARRY: begin
        rd_addr = k - 1'b1;
      end
      ST_COMPARE: begin
        // The record that loses the compare settles at k; the other moves on.
        wr_en   = 1'b1;
        wr_addr = k;
        wr_data = swap ? rd_data : carry;
        rd_addr = k - 1'b1 - 1'b1;
      end
      ST_PASS_END: begin
        // The carried record lands at the bottom of this pass, and the top
        // record is fetched for the next pass.
        wr_en   = 1'b1;
        wr_addr = pass - 1'b1;
        wr_data = carry;
        rd_addr = nm1;
      end
      ST_EMIT_READ: begin
        rd_addr = e_idx;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      descending  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
          CFG_DESCENDING:  descending  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (state == ST_EMIT_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sort indexes, carried record and the output register.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pass  <= IDX_W'(1);
        k     <= nm1;
        e_idx <= '0;
      end
      ST_LOAD_CARRY: begin
        carry <= rd_data;
      end
      ST_COMPARE: begin
        if (!swap) begin
          carry <= rd_data;
        end
        if (k != pass) begin
          k <= k - 1'b1;
        end
      end
      ST_PASS_END: begin
        pass  <= pass + 1'b1;
        k     <= nm1;
        e_idx <= '0;
      end
      ST_EMIT_LOAD: begin
        out_score <= rd_data[SCORE_W-1:0];
        out_tag   <= TAG_W'(rd_data[WORD_W-1:SCORE_W]);
        rank      <= RANK_W'(e_idx);
        final_res <= (e_idx == nm1);
      end
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          e_idx <= e_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/stbs_checker.sv
`timescale 1ns / 1ps
`include "score_tag_bubble_sorter_defines.svh"
module stbs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [stbs_pkg::RANK_W-1:0]         rank,
  input logic                                final_res
);
  import stbs_pkg::*;

  // The input is never taken while a sorted record is on offer.
  `STBS_ASSERT_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid), "in_ready during output")

  // An item that does not close a run leaves the block ready for the next one.
  `STBS_ASSERT_NEXT(a_plain_item_ready, clk, rst, in_valid && in_ready && !last, in_ready, "stalled after plain item")

  // Taking the final record returns the block to accepting items.
  `STBS_ASSERT_NEXT(a_final_returns, clk, rst, out_valid && out_ready && final_res, in_ready && !out_valid, "not ready after final record")

  // A stalled result stays on offer with the same rank.
  `STBS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(rank), "result dropped while stalled")

endmodule

bind score_tag_bubble_sorter stbs_checker u_stbs_checker (.*);

>>> tb/sv/tb_score_tag_bubble_sorter.sv
`timescale 1ns / 1ps
module tb_score_tag_bubble_sorter;
  import stbs_pkg::*;

  localparam int SLOTS       = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;

  // One record write as the sender presents it. A held item is not offered
  // until every sorted record that is still owed has come out.
  typedef struct {
    logic [SLOT_W-1:0]         slot;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic                      last;
    logic                      hold;
  } rec_write_t;

  // One record of a sorted run as it should leave the block.
  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [RANK_W-1:0]         rank;
    logic                      fin;
  } sorted_rec_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [SLOT_W-1:0]           slot = '0;
  logic signed [SCORE_W-1:0]   score = '0;
  logic [TAG_W-1:0]            tag = '0;
  logic                        last = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SCORE_W-1:0]   out_score;
  logic [TAG_W-1:0]            out_tag;
  logic [RANK_W-1:0]           rank;
  logic                        final_res;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // Pending record writes for the sender, and sorted records still owed.
  rec_write_t  write_q[$];
  sorted_rec_t sorted_q[$];

  // Our own copy of the block's store and registers.
  logic signed [SCORE_W-1:0] score_mem [SLOTS];
  logic [TAG_W-1:0]          tag_mem [SLOTS];
  logic [COUNT_W-1:0]        count_reg = '0;
  logic                      order_desc = 1'b0;

  int  fail_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  cycle_cnt = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  rec_write_t next_rec;

  score_tag_bubble_sorter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot      (slot),
    .score     (score),
    .tag       (tag),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_score (out_score),
    .out_tag   (out_tag),
    .rank      (rank),
    .final_res (final_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Applies one accepted record write to our copy of the store. On a last
  // item the records in use are bubble sorted in place, swapping only on a
  // strict compare so that equal scores keep their order, and the whole
  // sorted run is queued as expected output.
  function automatic void store_and_sort(input logic [SLOT_W-1:0] wr_slot,
                                         input logic signed [SCORE_W-1:0] wr_score,
                                         input logic [TAG_W-1:0] wr_tag,
                                         input logic wr_last);
    int unsigned  n;
    bit           swap;
    logic signed [SCORE_W-1:0] s_tmp;
    logic [TAG_W-1:0]          t_tmp;
    sorted_rec_t  rec;
    n = (count_reg > SLOTS) ? SLOTS : count_reg;
    if (wr_slot < n) begin
      score_mem[wr_slot] = wr_score;
      tag_mem[wr_slot] = wr_tag;
    end
    if (!wr_last || n == 0) return;
    for (int unsigned p = 1; p < n; p++) begin
      for (int unsigned k = n - 1; k >= p; k--) begin
        swap = order_desc ? (score_mem[k-1] < score_mem[k])
                          : (score_mem[k] < score_mem[k-1]);
        if (swap) begin
          s_tmp = score_mem[k-1];
          score_mem[k-1] = score_mem[k];
          score_mem[k] = s_tmp;
          t_tmp = tag_mem[k-1];
          tag_mem[k-1] = tag_mem[k];
          tag_mem[k] = t_tmp;
        end
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      rec.score = score_mem[k];
      rec.tag = tag_mem[k];
      rec.rank = k[RANK_W-1:0];
      rec.fin = (k == n - 1);
      sorted_q.push_back(rec);
    end
  endfunction

  // Sender. An accepted item goes to the predictor at the edge that takes it;
  // then the next item is offered after its own random gap. Valid is only
  // changed while nothing is waiting to be taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        store_and_sort(slot, score, tag, last);
        gap_left = in_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (write_q.size() != 0 &&
                     !(write_q[0].hold && sorted_q.size() != 0)) begin
          next_rec = write_q.pop_front();
          slot <= next_rec.slot;
          score <= next_rec.score;
          tag <= next_rec.tag;
          last <= next_rec.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each taken record is checked against the oldest expectation,
  // field by field. Before the next record the receiver holds ready low for
  // a random number of cycles in which a record is on offer.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          $error("sorted record with none expected: score %0d tag %h rank %0d",
                 out_score, out_tag, rank);
          fail_cnt++;
        end else begin
          if (out_score !== sorted_q[0].score) begin
            $error("out_score expected %0d actual %0d", sorted_q[0].score, out_score);
            fail_cnt++;
          end
          if (out_tag !== sorted_q[0].tag) begin
            $error("out_tag expected %h actual %h", sorted_q[0].tag, out_tag);
            fail_cnt++;
          end
          if (rank !== sorted_q[0].rank) begin
            $error("rank expected %0d actual %0d", sorted_q[0].rank, rank);
            fail_cnt++;
          end
          if (final_res !== sorted_q[0].fin) begin
            $error("final_res expected %0b actual %0b", sorted_q[0].fin, final_res);
            fail_cnt++;
          end
          void'(sorted_q.pop_front());
        end
        stall_left = out_idle_on ? $urandom_range(0, 9) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("score_tag_bubble_sorter verification failed");
      $finish;
    end
  end

  task automatic queue_record(input logic [SLOT_W-1:0] s, input logic signed [SCORE_W-1:0] v,
                              input logic [TAG_W-1:0] t, input logic l, input logic h = 1'b0);
    rec_write_t r;
    r.slot = s;
    r.score = v;
    r.tag = t;
    r.last = l;
    r.hold = h;
    write_q.push_back(r);
  endtask

  // One register write. The predictor takes the new value at the edge where
  // the write happens, which is always while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_ENTRY_COUNT) count_reg = val;
    else if (idx == CFG_DESCENDING) order_desc = val[0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every queued item has been taken and every sorted record has
  // come out. A trailing item that sorts nothing may still be in flight, so the
  // task does not return at once, and only then may a register write follow.
  task automatic wait_quiet();
    do @(posedge clk); while (write_q.size() != 0 || in_valid || sorted_q.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  // Scores lean toward a narrow band so that ties, and with them the
  // stability of the sort, come up often.
  function automatic logic signed [SCORE_W-1:0] draw_score();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2, 3: return $signed($urandom_range(0, 6) - 3) <<< 16;
      4: return $signed($urandom_range(0, 3)) - 2;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int unsigned eff;
    int unsigned len;
    int unsigned pick;
    int unsigned rand_cnt;
    logic [SLOT_W-1:0] s;
    logic l;
    logic prev_last;
    logic [CFG_DATA_W-1:0] new_count;

    rand_cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      score_mem[i] = '0;
      tag_mem[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With no records in use, writes are dropped and a last item emits nothing.
    queue_record(5'd31, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1);
    queue_record(5'd0, 32'sh8000_0000, 16'h0000, 1'b1);
    wait_quiet();

    // Four records ascending: extremes, two zero scores that must keep their
    // order, one untouched reset slot, and a last item whose own write falls
    // outside the records in use.
    write_reg(CFG_ENTRY_COUNT, 6'd4);
    write_reg(CFG_DESCENDING, 6'd0);
    queue_record(5'd0, 32'sh8000_0000, 16'h0001, 1'b0);
    queue_record(5'd1, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
    queue_record(5'd2, 32'sh0000_0000, 16'h1234, 1'b0);
    queue_record(5'd5, 32'sh0005_0000, 16'h5555, 1'b1);
    wait_quiet();

    // A count beyond the store is clamped to the full store; sort descending.
    write_reg(CFG_ENTRY_COUNT, 6'd63);
    write_reg(CFG_DESCENDING, 6'd1);
    queue_record(5'd0, -32'sd1, 16'hAAAA, 1'b0);
    queue_record(5'd1, -32'sd1, 16'h5555, 1'b0);
    queue_record(5'd31, 32'sh0001_8000, 16'h0F0F, 1'b0);
    queue_record(5'd30, 32'sh8000_0000, 16'hF0F0, 1'b1);
    // The sender waits here for the whole sorted run before going on.
    queue_record(5'd16, 32'sh0002_0000, 16'h00FF, 1'b1, 1'b1);
    wait_quiet();

    // A single record, then the full store ascending, then two records.
    write_reg(CFG_ENTRY_COUNT, 6'd1);
    write_reg(CFG_DESCENDING, 6'd0);
    queue_record(5'd0, 32'sh1234_5678, 16'hBEEF, 1'b1);
    wait_quiet();
    write_reg(CFG_ENTRY_COUNT, 6'd32);
    queue_record(5'd17, 32'shFFF9_0000, 16'h0001, 1'b1);
    wait_quiet();
    write_reg(CFG_ENTRY_COUNT, 6'd2);
    queue_record(5'd3, 32'sh0003_0000, 16'h0003, 1'b1);
    wait_quiet();

    // Random phases: each may set up a new record count and order, then sends a
    // burst of writes to the slots in use that ends in a last item. Some
    // writes stray outside the records in use, some bursts lose their last
    // flag, and some carry an early last.
    while (rand_cnt < 200) begin
      wait_quiet();
      pick = $urandom_range(0, 19);
      if (pick == 0) new_count = 6'd0;
      else if (pick == 1) new_count = CFG_DATA_W'($urandom_range(33, 63));
      else if (pick < 4) new_count = CFG_DATA_W'($urandom_range(21, 32));
      else if (pick < 8) new_count = CFG_DATA_W'($urandom_range(9, 20));
      else new_count = CFG_DATA_W'($urandom_range(1, 8));
      if ($urandom_range(0, 4) != 0) write_reg(CFG_ENTRY_COUNT, new_count);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_DESCENDING, CFG_DATA_W'($urandom_range(0, 63)));
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      eff = (count_reg > SLOTS) ? SLOTS : count_reg;
      len = $urandom_range(1, eff + 2);
      prev_last = 1'b0;
      for (int unsigned j = 0; j < len; j++) begin
        if (eff == 0 || $urandom_range(0, 7) == 0) s = SLOT_W'($urandom_range(0, SLOTS - 1));
        else s = SLOT_W'($urandom_range(0, eff - 1));
        if (j == len - 1) l = ($urandom_range(0, 7) != 0);
        else l = ($urandom_range(0, 15) == 0);
        queue_record(s, draw_score(), TAG_W'($urandom()), l,
                     prev_last && $urandom_range(0, 1));
        if (s < eff || l) rand_cnt++;
        prev_last = l;
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("score_tag_bubble_sorter verification clean");
    end else begin
      $display("score_tag_bubble_sorter verification failed");
    end
    $finish;
  end

endmodule
